>>> hdl/rgb_to_color_space_core_assert.svh
// ---------------------------------------------------------------------------
// RGB color space converter assertion macros
// Concurrent checks written against the converter clock and reset.
// ---------------------------------------------------------------------------
`ifndef RGB_TO_COLOR_SPACE_CORE_ASSERT_SVH
`define RGB_TO_COLOR_SPACE_CORE_ASSERT_SVH
`define RGBCS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgbcs check failed");
`define RGBCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgbcs check failed");
`endif

>>> hdl/rgbcs_pkg.sv
// ---------------------------------------------------------------------------
// RGB color space converter package
// Shared widths, space codes, matrix coefficients and pipeline types.
// ---------------------------------------------------------------------------
package rgbcs_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 12;

  typedef logic signed [COMP_WIDTH-1:0] comp_t;

  localparam comp_t COMP_MAX = comp_t'(2**(COMP_WIDTH-1) - 1);
  localparam comp_t COMP_MIN = comp_t'(-(2**(COMP_WIDTH-1)));

  localparam logic [2:0] SPACE_RGB = 3'd0;
  localparam logic [2:0] SPACE_HSL = 3'd1;
  localparam logic [2:0] SPACE_HSV = 3'd2;
  localparam logic [2:0] SPACE_XYZ = 3'd3;
  localparam logic [2:0] SPACE_CIE = 3'd4;
  localparam logic [2:0] SPACE_YIQ = 3'd5;
  localparam logic [2:0] SPACE_XYY = 3'd6;
  localparam logic [2:0] SPACE_BAD = 3'd7;

  localparam int COEF_W = 21;
  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t XYZ_COEF [3][3] = '{
    '{21'sd412453, 21'sd357580, 21'sd180423},
    '{21'sd212671, 21'sd715160, 21'sd72169},
    '{21'sd19334,  21'sd119193, 21'sd950227}
  };

  localparam coef_t YIQ_COEF [3][3] = '{
    '{21'sd299000, 21'sd587000, 21'sd114000},
    '{21'sd596000, -21'sd275000, -21'sd321000},
    '{21'sd212000, -21'sd523000, 21'sd311000}
  };

  // Matrix rows are divided by one million as a shift by 6 and a
  // reciprocal multiply by 1/15625 that is exact for 30-bit operands.
  localparam int PROD_W      = COMP_WIDTH + COEF_W;
  localparam int ACC_W       = PROD_W + 2;
  localparam int COEF_HALF   = 500000;
  localparam int REC_LO      = 6;
  localparam int REC_X_W     = 30;
  localparam int REC_M_W     = 31;
  localparam logic [REC_M_W-1:0] REC_MULT = 31'd1125899907;
  localparam int REC_SHIFT   = 44;
  localparam int MAT_Q_W     = COMP_WIDTH + 1;
  localparam int MAT_W       = COMP_WIDTH + 2;
  localparam int SUM_W       = COMP_WIDTH + 4;

  localparam int S_W   = COMP_WIDTH + 1;
  localparam int HSL_W = COMP_WIDTH + 2;
  localparam int HN_W  = COMP_WIDTH + 5;

  localparam logic signed [HSL_W-1:0] HSL_ONE = HSL_W'(2**FRAC_BITS);
  localparam logic signed [HSL_W-1:0] HSL_TWO = HSL_W'(2**(FRAC_BITS+1));

  localparam int DIV_W     = COMP_WIDTH + 3;
  localparam int DIV_QBITS = COMP_WIDTH + 1;
  localparam int DIV_PRE   = COMP_WIDTH - FRAC_BITS;
  localparam int DIV_LAT   = DIV_QBITS + 1;
  localparam logic [DIV_QBITS:0] DIV_RND_LIM = (DIV_QBITS+1)'(2**(COMP_WIDTH-1));

  typedef struct packed {
    logic [DIV_W-1:0] num;
    logic [DIV_W-1:0] den;
    logic             neg;
  } div_op_t;

  typedef struct packed {
    comp_t c0;
    comp_t c1;
    comp_t c2;
    logic  use_div0;
    logic  use_div1;
    logic  undef;
    logic  bad;
  } side_t;

endpackage

>>> hdl/rgbcs_div.sv
// ---------------------------------------------------------------------------
// RGB color space converter divider
// Pipelined restoring divider, one quotient bit per stage, giving the
// rounded and saturated signed fraction num / den at the component scale.
// ---------------------------------------------------------------------------
module rgbcs_div (
  input  logic              clk,
  input  logic              en,
  input  rgbcs_pkg::div_op_t op_i,
  output rgbcs_pkg::comp_t  res_o
);

  logic [rgbcs_pkg::DIV_W-1:0]     rem_r  [rgbcs_pkg::DIV_QBITS];
  logic [rgbcs_pkg::DIV_W-1:0]     den_r  [rgbcs_pkg::DIV_QBITS];
  logic [rgbcs_pkg::DIV_QBITS-1:0] bits_r [rgbcs_pkg::DIV_QBITS];
  logic [rgbcs_pkg::DIV_QBITS-1:0] q_r    [rgbcs_pkg::DIV_QBITS+1];
  logic                            ovf_r  [rgbcs_pkg::DIV_QBITS+1];
  logic                            neg_r  [rgbcs_pkg::DIV_QBITS+1];

  logic [rgbcs_pkg::DIV_W-1:0] rem_nxt;
  assign rem_nxt = op_i.num >> rgbcs_pkg::DIV_PRE;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= rem_nxt;
      den_r[0]  <= op_i.den;
      bits_r[0] <= {op_i.num[rgbcs_pkg::DIV_PRE-1:0], (rgbcs_pkg::FRAC_BITS+1)'(0)};
      q_r[0]    <= '0;
      ovf_r[0]  <= rem_nxt >= op_i.den;
      neg_r[0]  <= op_i.neg;
    end
  end

  for (genvar k = 0; k < rgbcs_pkg::DIV_QBITS; k++) begin : g_step
    logic [rgbcs_pkg::DIV_W:0] trial;
    logic [rgbcs_pkg::DIV_W:0] diff;
    logic                      ge;
    assign trial = {rem_r[k], bits_r[k][rgbcs_pkg::DIV_QBITS-1]};
    assign diff  = trial - {1'b0, den_r[k]};
    assign ge    = trial >= {1'b0, den_r[k]};

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k+1]   <= {q_r[k][rgbcs_pkg::DIV_QBITS-2:0], ge};
        ovf_r[k+1] <= ovf_r[k];
        neg_r[k+1] <= neg_r[k];
      end
    end

    if (k < rgbcs_pkg::DIV_QBITS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1]  <= ge ? diff[rgbcs_pkg::DIV_W-1:0] : trial[rgbcs_pkg::DIV_W-1:0];
          den_r[k+1]  <= den_r[k];
          bits_r[k+1] <= bits_r[k] << 1;
        end
      end
    end
  end

  logic [rgbcs_pkg::DIV_QBITS:0] rnd;
  logic                          big;
  assign rnd = ({1'b0, q_r[rgbcs_pkg::DIV_QBITS]} + (rgbcs_pkg::DIV_QBITS+1)'(1)) >> 1;
  assign big = ovf_r[rgbcs_pkg::DIV_QBITS] || (rnd >= rgbcs_pkg::DIV_RND_LIM);

  always_comb begin
    if (neg_r[rgbcs_pkg::DIV_QBITS]) begin
      res_o = big ? rgbcs_pkg::COMP_MIN
                  : -rgbcs_pkg::comp_t'(rnd[rgbcs_pkg::COMP_WIDTH-1:0]);
    end else begin
      res_o = big ? rgbcs_pkg::COMP_MAX
                  : rgbcs_pkg::comp_t'(rnd[rgbcs_pkg::COMP_WIDTH-1:0]);
    end
  end

endmodule

>>> hdl/rgb_to_color_space_core.sv
// ---------------------------------------------------------------------------
// RGB color space converter
// Converts one signed Q3.12 RGB color per request into RGB, HSL, HSV, XYZ,
// YIQ or xyY, with saturated results and grey and unknown-space flags.
// ---------------------------------------------------------------------------
// It accepts one request every clock unless the output stalls, and each
// result passes four stages of min/max, matrix products and the divide by
// one million, eighteen stages of the restoring divider that retires one
// quotient bit per stage, and the output register. When the output waits,
// the whole pipeline holds.
module rgb_to_color_space_core (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       in_req_type,
  input  rgbcs_pkg::comp_t in_red_in,
  input  rgbcs_pkg::comp_t in_green_in,
  input  rgbcs_pkg::comp_t in_blue_in,
  output logic             out_valid,
  input  logic             out_ready,
  output rgbcs_pkg::comp_t out_comp0_out,
  output rgbcs_pkg::comp_t out_comp1_out,
  output rgbcs_pkg::comp_t out_comp2_out,
  output logic             out_hue_undefined,
  output logic             out_bad_space
);

  function automatic rgbcs_pkg::comp_t sat_mat(input logic signed [rgbcs_pkg::MAT_W-1:0] v);
    if (v > rgbcs_pkg::MAT_W'(rgbcs_pkg::COMP_MAX)) begin
      return rgbcs_pkg::COMP_MAX;
    end else if (v < rgbcs_pkg::MAT_W'(rgbcs_pkg::COMP_MIN)) begin
      return rgbcs_pkg::COMP_MIN;
    end
    return rgbcs_pkg::comp_t'(v);
  endfunction

  logic pipe_en;
  logic out_valid_r;
  assign pipe_en  = !out_valid_r || out_ready;
  assign in_ready = pipe_en;

  // Stage 1: min, max and matrix products.
  rgbcs_pkg::comp_t rgb_in [3];
  assign rgb_in[0] = in_red_in;
  assign rgb_in[1] = in_green_in;
  assign rgb_in[2] = in_blue_in;

  rgbcs_pkg::comp_t max_nxt, min_nxt;
  always_comb begin
    max_nxt = (in_red_in > in_green_in) ? in_red_in : in_green_in;
    if (in_blue_in > max_nxt) begin
      max_nxt = in_blue_in;
    end
    min_nxt = (in_red_in < in_green_in) ? in_red_in : in_green_in;
    if (in_blue_in < min_nxt) begin
      min_nxt = in_blue_in;
    end
  end

  logic use_yiq;
  assign use_yiq = in_req_type == rgbcs_pkg::SPACE_YIQ;

  logic signed [rgbcs_pkg::PROD_W-1:0] prod_nxt [3][3];
  for (genvar i = 0; i < 3; i++) begin : g_row
    for (genvar j = 0; j < 3; j++) begin : g_col
      rgbcs_pkg::coef_t coef;
      assign coef = use_yiq ? rgbcs_pkg::YIQ_COEF[i][j] : rgbcs_pkg::XYZ_COEF[i][j];
      assign prod_nxt[i][j] = rgbcs_pkg::PROD_W'(rgb_in[j]) * rgbcs_pkg::PROD_W'(coef);
    end
  end

  logic                                v1_r;
  logic [2:0]                          sel1_r;
  rgbcs_pkg::comp_t                    rgb1_r [3];
  rgbcs_pkg::comp_t                    max1_r, min1_r;
  logic signed [rgbcs_pkg::PROD_W-1:0] prod1_r [3][3];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sel1_r  <= in_req_type;
      rgb1_r  <= rgb_in;
      max1_r  <= max_nxt;
      min1_r  <= min_nxt;
      prod1_r <= prod_nxt;
    end
  end

  // Stage 2: row sums, rounding offset, HSL and HSV operands.
  logic [rgbcs_pkg::REC_X_W-1:0] x_nxt [3];
  logic                          xneg_nxt [3];
  always_comb begin
    logic signed [rgbcs_pkg::ACC_W-1:0] acc;
    logic [rgbcs_pkg::ACC_W-1:0]        mag;
    for (int i = 0; i < 3; i++) begin
      acc = rgbcs_pkg::ACC_W'(prod1_r[i][0]) + rgbcs_pkg::ACC_W'(prod1_r[i][1])
          + rgbcs_pkg::ACC_W'(prod1_r[i][2]);
      xneg_nxt[i] = acc[rgbcs_pkg::ACC_W-1];
      mag = acc[rgbcs_pkg::ACC_W-1] ? rgbcs_pkg::ACC_W'(-acc) : rgbcs_pkg::ACC_W'(acc);
      mag = mag + rgbcs_pkg::ACC_W'(rgbcs_pkg::COEF_HALF);
      x_nxt[i] = mag[rgbcs_pkg::REC_LO +: rgbcs_pkg::REC_X_W];
    end
  end

  logic signed [rgbcs_pkg::S_W-1:0]     sum_mm, d_full;
  logic [rgbcs_pkg::S_W-1:0]            mag_s, half_s;
  logic [rgbcs_pkg::COMP_WIDTH-1:0]     d_nxt;
  rgbcs_pkg::comp_t                     light_nxt;
  logic signed [rgbcs_pkg::HSL_W-1:0]   s_ext, den_hsl_nxt;
  logic signed [rgbcs_pkg::HN_W-1:0]    d_s, d6_s, hn, r_s, g_s, b_s;
  logic [rgbcs_pkg::DIV_W-1:0]          hue_num_nxt, hue_den_nxt;

  always_comb begin
    sum_mm = rgbcs_pkg::S_W'(max1_r) + rgbcs_pkg::S_W'(min1_r);
    d_full = rgbcs_pkg::S_W'(max1_r) - rgbcs_pkg::S_W'(min1_r);
    d_nxt  = d_full[rgbcs_pkg::COMP_WIDTH-1:0];
    mag_s  = sum_mm[rgbcs_pkg::S_W-1] ? rgbcs_pkg::S_W'(-sum_mm) : rgbcs_pkg::S_W'(sum_mm);
    half_s = (mag_s + rgbcs_pkg::S_W'(1)) >> 1;
    light_nxt = sum_mm[rgbcs_pkg::S_W-1]
              ? -rgbcs_pkg::comp_t'(half_s[rgbcs_pkg::COMP_WIDTH-1:0])
              : rgbcs_pkg::comp_t'(half_s[rgbcs_pkg::COMP_WIDTH-1:0]);
    s_ext = rgbcs_pkg::HSL_W'(sum_mm);
    den_hsl_nxt = (s_ext < rgbcs_pkg::HSL_ONE) ? s_ext : rgbcs_pkg::HSL_TWO - s_ext;

    d_s  = $signed({(rgbcs_pkg::HN_W-rgbcs_pkg::COMP_WIDTH)'(0), d_nxt});
    d6_s = (d_s <<< 2) + (d_s <<< 1);
    r_s  = rgbcs_pkg::HN_W'(rgb1_r[0]);
    g_s  = rgbcs_pkg::HN_W'(rgb1_r[1]);
    b_s  = rgbcs_pkg::HN_W'(rgb1_r[2]);
    if (rgb1_r[0] == max1_r) begin
      hn = g_s - b_s;
    end else if (rgb1_r[1] == max1_r) begin
      hn = (d_s <<< 1) + b_s - r_s;
    end else begin
      hn = (d_s <<< 2) + r_s - g_s;
    end
    if (hn < 0) begin
      hn = hn + d6_s;
    end
    hue_num_nxt = hn[rgbcs_pkg::DIV_W-1:0];
    hue_den_nxt = d6_s[rgbcs_pkg::DIV_W-1:0];
  end

  logic                                 v2_r;
  logic [2:0]                           sel2_r;
  rgbcs_pkg::comp_t                     rgb2_r [3];
  rgbcs_pkg::comp_t                     max2_r, light2_r;
  logic [rgbcs_pkg::REC_X_W-1:0]        x2_r [3];
  logic                                 xneg2_r [3];
  logic [rgbcs_pkg::COMP_WIDTH-1:0]     d2_r;
  logic signed [rgbcs_pkg::HSL_W-1:0]   den_hsl2_r;
  logic [rgbcs_pkg::DIV_W-1:0]          hue_num2_r, hue_den2_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sel2_r     <= sel1_r;
      rgb2_r     <= rgb1_r;
      max2_r     <= max1_r;
      light2_r   <= light_nxt;
      x2_r       <= x_nxt;
      xneg2_r    <= xneg_nxt;
      d2_r       <= d_nxt;
      den_hsl2_r <= den_hsl_nxt;
      hue_num2_r <= hue_num_nxt;
      hue_den2_r <= hue_den_nxt;
    end
  end

  // Stage 3: reciprocal multiply for the divide by 15625.
  logic [rgbcs_pkg::MAT_Q_W-1:0] q_nxt [3];
  for (genvar i = 0; i < 3; i++) begin : g_rec
    logic [rgbcs_pkg::REC_X_W+rgbcs_pkg::REC_M_W-1:0] pm;
    assign pm = (rgbcs_pkg::REC_X_W+rgbcs_pkg::REC_M_W)'(x2_r[i])
              * (rgbcs_pkg::REC_X_W+rgbcs_pkg::REC_M_W)'(rgbcs_pkg::REC_MULT);
    assign q_nxt[i] = pm[rgbcs_pkg::REC_SHIFT +: rgbcs_pkg::MAT_Q_W];
  end

  logic                               v3_r;
  logic [2:0]                         sel3_r;
  rgbcs_pkg::comp_t                   rgb3_r [3];
  rgbcs_pkg::comp_t                   max3_r, light3_r;
  logic [rgbcs_pkg::MAT_Q_W-1:0]      q3_r [3];
  logic                               xneg3_r [3];
  logic [rgbcs_pkg::COMP_WIDTH-1:0]   d3_r;
  logic signed [rgbcs_pkg::HSL_W-1:0] den_hsl3_r;
  logic [rgbcs_pkg::DIV_W-1:0]        hue_num3_r, hue_den3_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sel3_r     <= sel2_r;
      rgb3_r     <= rgb2_r;
      max3_r     <= max2_r;
      light3_r   <= light2_r;
      q3_r       <= q_nxt;
      xneg3_r    <= xneg2_r;
      d3_r       <= d2_r;
      den_hsl3_r <= den_hsl2_r;
      hue_num3_r <= hue_num2_r;
      hue_den3_r <= hue_den2_r;
    end
  end

  // Stage 4: signed matrix results, xyY sum, divider operands and bypass values.
  logic signed [rgbcs_pkg::MAT_W-1:0] mat [3];
  logic signed [rgbcs_pkg::SUM_W-1:0] xyz_sum;
  logic [rgbcs_pkg::SUM_W-1:0]        sum_abs;
  logic [rgbcs_pkg::MAT_W-1:0]        x_abs, y_abs;
  logic [rgbcs_pkg::HSL_W-1:0]        den_hsl_abs;
  logic [rgbcs_pkg::COMP_WIDTH:0]     max_abs;
  rgbcs_pkg::side_t                   side_nxt;
  rgbcs_pkg::div_op_t                 div0_nxt, div1_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mat[i] = xneg3_r[i] ? -rgbcs_pkg::MAT_W'(q3_r[i]) : rgbcs_pkg::MAT_W'(q3_r[i]);
    end
    xyz_sum = rgbcs_pkg::SUM_W'(mat[0]) + rgbcs_pkg::SUM_W'(mat[1])
            + rgbcs_pkg::SUM_W'(mat[2]);
    sum_abs = xyz_sum[rgbcs_pkg::SUM_W-1] ? rgbcs_pkg::SUM_W'(-xyz_sum)
                                          : rgbcs_pkg::SUM_W'(xyz_sum);
    x_abs = mat[0][rgbcs_pkg::MAT_W-1] ? rgbcs_pkg::MAT_W'(-mat[0]) : rgbcs_pkg::MAT_W'(mat[0]);
    y_abs = mat[1][rgbcs_pkg::MAT_W-1] ? rgbcs_pkg::MAT_W'(-mat[1]) : rgbcs_pkg::MAT_W'(mat[1]);
    den_hsl_abs = den_hsl3_r[rgbcs_pkg::HSL_W-1] ? rgbcs_pkg::HSL_W'(-den_hsl3_r)
                                                 : rgbcs_pkg::HSL_W'(den_hsl3_r);
    max_abs = max3_r[rgbcs_pkg::COMP_WIDTH-1] ? -(rgbcs_pkg::COMP_WIDTH+1)'(max3_r)
                                              : (rgbcs_pkg::COMP_WIDTH+1)'(max3_r);

    side_nxt = '0;
    div0_nxt.num = hue_num3_r;
    div0_nxt.den = hue_den3_r;
    div0_nxt.neg = 1'b0;
    div1_nxt.num = rgbcs_pkg::DIV_W'(d3_r);
    div1_nxt.den = rgbcs_pkg::DIV_W'(den_hsl_abs);
    div1_nxt.neg = den_hsl3_r[rgbcs_pkg::HSL_W-1];

    case (sel3_r)
      rgbcs_pkg::SPACE_RGB: begin
        side_nxt.c0 = rgb3_r[0];
        side_nxt.c1 = rgb3_r[1];
        side_nxt.c2 = rgb3_r[2];
      end
      rgbcs_pkg::SPACE_HSL: begin
        side_nxt.c2 = light3_r;
        if (d3_r == '0) begin
          side_nxt.undef = 1'b1;
        end else begin
          side_nxt.use_div0 = 1'b1;
          if (den_hsl3_r == '0) begin
            side_nxt.c1 = rgbcs_pkg::COMP_MAX;
          end else begin
            side_nxt.use_div1 = 1'b1;
          end
        end
      end
      rgbcs_pkg::SPACE_HSV: begin
        side_nxt.c2  = max3_r;
        div1_nxt.den = rgbcs_pkg::DIV_W'(max_abs);
        div1_nxt.neg = max3_r[rgbcs_pkg::COMP_WIDTH-1];
        if (max3_r == '0 || d3_r == '0) begin
          side_nxt.undef = 1'b1;
        end else begin
          side_nxt.use_div0 = 1'b1;
          side_nxt.use_div1 = 1'b1;
        end
      end
      rgbcs_pkg::SPACE_XYZ, rgbcs_pkg::SPACE_CIE, rgbcs_pkg::SPACE_YIQ: begin
        side_nxt.c0 = sat_mat(mat[0]);
        side_nxt.c1 = sat_mat(mat[1]);
        side_nxt.c2 = sat_mat(mat[2]);
      end
      rgbcs_pkg::SPACE_XYY: begin
        div0_nxt.num = rgbcs_pkg::DIV_W'(x_abs);
        div0_nxt.den = rgbcs_pkg::DIV_W'(sum_abs);
        div0_nxt.neg = mat[0][rgbcs_pkg::MAT_W-1] ^ xyz_sum[rgbcs_pkg::SUM_W-1];
        div1_nxt.num = rgbcs_pkg::DIV_W'(y_abs);
        div1_nxt.den = rgbcs_pkg::DIV_W'(sum_abs);
        div1_nxt.neg = mat[1][rgbcs_pkg::MAT_W-1] ^ xyz_sum[rgbcs_pkg::SUM_W-1];
        if (xyz_sum != '0) begin
          side_nxt.c2       = sat_mat(mat[1]);
          side_nxt.use_div0 = 1'b1;
          side_nxt.use_div1 = 1'b1;
        end
      end
      rgbcs_pkg::SPACE_BAD: begin
        side_nxt.bad = 1'b1;
      end
      default: begin
        side_nxt.bad = 1'b1;
      end
    endcase
  end

  logic               v4_r;
  rgbcs_pkg::side_t   side4_r;
  rgbcs_pkg::div_op_t div0_4_r, div1_4_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side4_r  <= side_nxt;
      div0_4_r <= div0_nxt;
      div1_4_r <= div1_nxt;
    end
  end

  // Divider stages, with the bypass values traveling alongside.
  rgbcs_pkg::comp_t div0_res, div1_res;

  rgbcs_div u_div0 (
    .clk   (clk),
    .en    (pipe_en),
    .op_i  (div0_4_r),
    .res_o (div0_res)
  );

  rgbcs_div u_div1 (
    .clk   (clk),
    .en    (pipe_en),
    .op_i  (div1_4_r),
    .res_o (div1_res)
  );

  logic [rgbcs_pkg::DIV_LAT-1:0] v_line_r;
  rgbcs_pkg::side_t              side_line_r [rgbcs_pkg::DIV_LAT];

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      side_line_r[0] <= side4_r;
      for (int k = 1; k < rgbcs_pkg::DIV_LAT; k++) begin
        side_line_r[k] <= side_line_r[k-1];
      end
    end
  end

  // Output register.
  rgbcs_pkg::side_t side_out;
  assign side_out = side_line_r[rgbcs_pkg::DIV_LAT-1];

  rgbcs_pkg::comp_t out_comp0_r, out_comp1_r, out_comp2_r;
  logic             out_hue_undef_r, out_bad_space_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      out_comp0_r     <= side_out.use_div0 ? div0_res : side_out.c0;
      out_comp1_r     <= side_out.use_div1 ? div1_res : side_out.c1;
      out_comp2_r     <= side_out.c2;
      out_hue_undef_r <= side_out.undef;
      out_bad_space_r <= side_out.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v_line_r    <= '0;
      out_valid_r <= 1'b0;
    end else if (pipe_en) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      v_line_r    <= {v_line_r[rgbcs_pkg::DIV_LAT-2:0], v4_r};
      out_valid_r <= v_line_r[rgbcs_pkg::DIV_LAT-1];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_comp0_out     = out_comp0_r;
  assign out_comp1_out     = out_comp1_r;
  assign out_comp2_out     = out_comp2_r;
  assign out_hue_undefined = out_hue_undef_r;
  assign out_bad_space     = out_bad_space_r;

  logic out_comps_zero;
  assign out_comps_zero = (out_comp0_r == '0) && (out_comp1_r == '0) && (out_comp2_r == '0);

`include "rgb_to_color_space_core_assert.svh"

  `RGBCS_ASSERT_SAME(a_bad_space_zero, out_valid_r && out_bad_space_r, out_comps_zero && !out_hue_undef_r)
  `RGBCS_ASSERT_SAME(a_grey_hue_zero, out_valid_r && out_hue_undef_r, (out_comp0_r == '0) && !out_bad_space_r)
  `RGBCS_ASSERT_NEXT(a_stall_holds, !pipe_en, $stable({v_line_r, v4_r, out_comp0_r, out_comp1_r}))

endmodule

>>> sim/tb.sv
// ---------------------------------------------------------------------------
// RGB color space converter testbench
// Sends RGB requests for every target space through the valid/ready input,
// predicts each result in fixed point, and checks every returned result in
// order. The receiver stalls at random, with one long hold-off.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
  import rgbcs_pkg::*;

  typedef struct {
    comp_t c0;
    comp_t c1;
    comp_t c2;
    logic  undef;
    logic  bad;
  } color_res_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] in_req_type;
  comp_t      in_red_in;
  comp_t      in_green_in;
  comp_t      in_blue_in;
  logic       out_valid;
  logic       out_ready;
  comp_t      out_comp0_out;
  comp_t      out_comp1_out;
  comp_t      out_comp2_out;
  logic       out_hue_undefined;
  logic       out_bad_space;

  color_res_t pending_colors[$];
  int         mismatches;
  int         checked;
  int         sent_per_space[8];
  bit         no_idle;
  bit         long_hold;
  int         rx_hold_cycles;

  rgb_to_color_space_core dut (.*);

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #400000;
    $display("[rgb_to_color_space_core] ERROR");
    $finish;
  end

  function automatic comp_t clamp_comp(longint v);
    if (v > longint'(COMP_MAX)) return COMP_MAX;
    if (v < longint'(COMP_MIN)) return COMP_MIN;
    return comp_t'(v);
  endfunction

  function automatic longint unsigned frac_udiv(longint unsigned n, longint unsigned d);
    longint unsigned q, r, f;
    q = n / d;
    r = n % d;
    f = 0;
    if (q > (64'd1 << 34)) q = 64'd1 << 34;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      f = f << 1;
      if (r >= d) begin
        r = r - d;
        f = f | 1;
      end
    end
    if ((r << 1) >= d) f = f + 1;
    return (q << FRAC_BITS) + f;
  endfunction

  function automatic longint frac_sdiv(longint n, longint d);
    bit              neg;
    longint unsigned un, ud, q;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? longint'(-n) : n;
    ud = (d < 0) ? longint'(-d) : d;
    q = frac_udiv(un, ud);
    return neg ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint matrix_row(longint k0, longint k1, longint k2,
                                        longint r, longint g, longint b);
    longint acc, mag, q;
    acc = k0 * r + k1 * g + k2 * b;
    mag = (acc < 0) ? -acc : acc;
    q = (mag + 500000) / 1000000;
    return (acc < 0) ? -q : q;
  endfunction

  function automatic longint hue_turn(longint r, longint g, longint b,
                                      longint ma, longint d);
    longint n;
    if (r == ma) n = g - b;
    else if (g == ma) n = 2 * d + (b - r);
    else n = 4 * d + (r - g);
    if (n < 0) n = n + 6 * d;
    return longint'(frac_udiv(n, 6 * d));
  endfunction

  function automatic color_res_t convert_color(logic [2:0] space, comp_t red,
                                               comp_t green, comp_t blue);
    color_res_t res;
    longint     r, g, b, ma, mi, d, s, den, c0, c1, c2, x, y, z, sum;
    r = red;
    g = green;
    b = blue;
    c0 = 0;
    c1 = 0;
    c2 = 0;
    res.undef = 1'b0;
    res.bad = 1'b0;
    ma = (r > g) ? r : g;
    if (b > ma) ma = b;
    mi = (r < g) ? r : g;
    if (b < mi) mi = b;
    d = ma - mi;
    case (space)
      SPACE_RGB: begin
        c0 = r;
        c1 = g;
        c2 = b;
      end
      SPACE_HSL: begin
        s = ma + mi;
        c2 = (s >= 0) ? (s + 1) / 2 : -((-s + 1) / 2);
        if (d == 0) begin
          res.undef = 1'b1;
        end else begin
          den = (s < (64'sd1 << FRAC_BITS)) ? s : (64'sd1 << (FRAC_BITS + 1)) - s;
          c1 = (den == 0) ? longint'(COMP_MAX) : frac_sdiv(d, den);
          c0 = hue_turn(r, g, b, ma, d);
        end
      end
      SPACE_HSV: begin
        c2 = ma;
        if (ma == 0 || d == 0) begin
          res.undef = 1'b1;
        end else begin
          c1 = frac_sdiv(d, ma);
          c0 = hue_turn(r, g, b, ma, d);
        end
      end
      SPACE_XYZ, SPACE_CIE, SPACE_XYY: begin
        x = matrix_row(XYZ_COEF[0][0], XYZ_COEF[0][1], XYZ_COEF[0][2], r, g, b);
        y = matrix_row(XYZ_COEF[1][0], XYZ_COEF[1][1], XYZ_COEF[1][2], r, g, b);
        z = matrix_row(XYZ_COEF[2][0], XYZ_COEF[2][1], XYZ_COEF[2][2], r, g, b);
        if (space == SPACE_XYY) begin
          sum = x + y + z;
          if (sum != 0) begin
            c0 = frac_sdiv(x, sum);
            c1 = frac_sdiv(y, sum);
            c2 = y;
          end
        end else begin
          c0 = x;
          c1 = y;
          c2 = z;
        end
      end
      SPACE_YIQ: begin
        c0 = matrix_row(YIQ_COEF[0][0], YIQ_COEF[0][1], YIQ_COEF[0][2], r, g, b);
        c1 = matrix_row(YIQ_COEF[1][0], YIQ_COEF[1][1], YIQ_COEF[1][2], r, g, b);
        c2 = matrix_row(YIQ_COEF[2][0], YIQ_COEF[2][1], YIQ_COEF[2][2], r, g, b);
      end
      default: begin
        res.bad = 1'b1;
      end
    endcase
    res.c0 = clamp_comp(c0);
    res.c1 = clamp_comp(c1);
    res.c2 = clamp_comp(c2);
    return res;
  endfunction

  task automatic send_color(logic [2:0] space, comp_t red, comp_t green, comp_t blue);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_req_type <= space;
    in_red_in   <= red;
    in_green_in <= green;
    in_blue_in  <= blue;
    do @(posedge clk); while (!in_ready);
    pending_colors.push_back(convert_color(space, red, green, blue));
    sent_per_space[space]++;
  endtask

  task automatic idle_input();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic comp_t random_comp();
    case ($urandom_range(0, 3))
      0:       return comp_t'($urandom);
      1:       return comp_t'($urandom_range(0, 4096));
      2:       return comp_t'(int'($urandom_range(0, 12288)) - 4096);
      default: return comp_t'(int'($urandom_range(0, 512)) - 256);
    endcase
  endfunction

  task automatic send_random_color();
    comp_t r, g, b;
    r = random_comp();
    g = random_comp();
    b = random_comp();
    case ($urandom_range(0, 7))
      0:       g = r;
      1:       b = r;
      2: begin
        g = r;
        b = r;
      end
      default: ;
    endcase
    send_color(3'($urandom_range(0, 7)), r, g, b);
  endtask

  task automatic wait_drained();
    while (pending_colors.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    for (int sp = 0; sp < 8; sp++) begin
      send_color(3'(sp), COMP_MAX, COMP_MIN, 16'sd0);
      send_color(3'(sp), COMP_MIN, COMP_MIN, COMP_MIN);
    end
    send_color(SPACE_HSL, 16'sd4096, 16'sd4096, 16'sd4096);
    send_color(SPACE_HSL, 16'sd100, -16'sd100, 16'sd0);
    send_color(SPACE_HSL, 16'sd5000, 16'sd3192, 16'sd4000);
    send_color(SPACE_HSV, 16'sd0, -16'sd5, -16'sd10);
    send_color(SPACE_HSV, 16'sd2000, 16'sd2000, 16'sd2000);
    send_color(SPACE_XYY, 16'sd0, 16'sd0, 16'sd0);
    send_color(SPACE_XYY, 16'sd4096, -16'sd4096, 16'sd0);
    send_color(SPACE_HSV, 16'sd4096, 16'sd0, 16'sd4095);
    send_color(SPACE_YIQ, COMP_MAX, COMP_MAX, COMP_MAX);
  endtask

  task automatic test_random_mix(int count);
    for (int i = 0; i < count; i++) send_random_color();
  endtask

  task automatic test_no_idle_burst(int count);
    no_idle = 1'b1;
    for (int i = 0; i < count; i++) send_random_color();
    no_idle = 1'b0;
  endtask

  task automatic test_output_backpressure(int count);
    rx_hold_cycles = 200;
    long_hold = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < count; i++) send_random_color();
    no_idle = 1'b0;
  endtask

  task automatic test_drain_pause(int count);
    idle_input();
    wait_drained();
    for (int i = 0; i < count; i++) send_random_color();
  endtask

  initial begin
    for (int k = 0; k < 8; k++) sent_per_space[k] = 0;
    mismatches     = 0;
    checked        = 0;
    no_idle        = 1'b0;
    long_hold      = 1'b0;
    rx_hold_cycles = 0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_req_type    = SPACE_RGB;
    in_red_in      = '0;
    in_green_in    = '0;
    in_blue_in     = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(300);
    test_no_idle_burst(100);
    test_output_backpressure(150);
    test_drain_pause(175);
    idle_input();
    wait_drained();
    repeat (40) @(posedge clk);
    $display("Checked %0d results over spaces rgb..bad: %0d %0d %0d %0d %0d %0d %0d %0d",
             checked, sent_per_space[0], sent_per_space[1], sent_per_space[2],
             sent_per_space[3], sent_per_space[4], sent_per_space[5],
             sent_per_space[6], sent_per_space[7]);
    $display("Random gaps on both sides, a long output stall and a full drain were covered.");
    if (mismatches == 0 && pending_colors.size() == 0) begin
      $display("[rgb_to_color_space_core] OK");
    end else begin
      $display("[rgb_to_color_space_core] ERROR");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ready <= 1'b0;
        repeat (rx_hold_cycles) @(posedge clk);
        long_hold = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    color_res_t exp_color;
    if (rst_n && out_valid && out_ready) begin
      checked++;
      if (pending_colors.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result: no request outstanding");
      end else begin
        exp_color = pending_colors.pop_front();
        if (out_comp0_out !== exp_color.c0 || out_comp1_out !== exp_color.c1 ||
            out_comp2_out !== exp_color.c2 || out_hue_undefined !== exp_color.undef ||
            out_bad_space !== exp_color.bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch: expected %0d %0d %0d u%0b b%0b, got %0d %0d %0d u%0b b%0b",
                     exp_color.c0, exp_color.c1, exp_color.c2, exp_color.undef,
                     exp_color.bad, out_comp0_out, out_comp1_out, out_comp2_out,
                     out_hue_undefined, out_bad_space);
          end
        end
      end
    end
  end

endmodule
